### hdl/tsq_pkg.sv
`default_nettype none

package tsq_pkg;

  // fixed field widths
  localparam int SAMPLE_BITS = 24;
  localparam int COUNT_BITS  = 16;
  localparam int TICK_BITS   = 32;
  localparam int WLEN_BITS   = 6;

  // calibration sum holds up to 65535 samples
  localparam int SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
  // tracking dividend is product plus one sample
  localparam int DVD_BITS  = SUM_BITS + 1;
  // divider retires two quotient bits per cycle
  localparam int DIV_STEPS = (DVD_BITS + 1) / 2;
  localparam int DVD_PAD   = 2 * DIV_STEPS;
  localparam int CNT_BITS  = $clog2(DIV_STEPS + 1);

  // trigger threshold is baseline * 201 / 200
  localparam int THR_NUM  = 201;
  localparam int THR_DEN  = 200;
  localparam int THR_BITS = SAMPLE_BITS + 8;

  localparam logic [COUNT_BITS-1:0] RC_MAX = '1;

  // edge codes
  localparam logic [1:0] EDGE_NONE = 2'd0;
  localparam logic [1:0] EDGE_RISE = 2'd1;
  localparam logic [1:0] EDGE_FALL = 2'd2;

  // register indexes
  localparam logic [1:0] REG_WINDOW  = 2'd0;
  localparam logic [1:0] REG_COUNT   = 2'd1;
  localparam logic [1:0] REG_SETTLE  = 2'd2;
  localparam logic [1:0] REG_TIMEOUT = 2'd3;

  // register reset values
  localparam logic [WLEN_BITS-1:0]  WINDOW_RST  = 6'd8;
  localparam logic [COUNT_BITS-1:0] COUNT_RST   = 16'd16;
  localparam logic [COUNT_BITS-1:0] SETTLE_RST  = 16'd100;
  localparam logic [TICK_BITS-1:0]  TIMEOUT_RST = 32'd180000000;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [TICK_BITS-1:0]   now_ticks;
  } tsq_in_t;

  typedef struct packed {
    logic [1:0]           edge_res;
    logic                 pressed;
    logic [TICK_BITS-1:0] state_duration;
    logic                 calibrating;
  } tsq_out_t;

  typedef struct packed {
    logic [WLEN_BITS-1:0]  window_length;
    logic [COUNT_BITS-1:0] baseline_count;
    logic [COUNT_BITS-1:0] settle_samples;
    logic [TICK_BITS-1:0]  hold_timeout_ticks;
  } tsq_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic calc;
    logic mul;
    logic div_load;
    logic div_step;
    logic wb;
    logic push;
  } tsq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic calc_mul;
    logic calc_div;
    logic div_last;
  } tsq_sts_t;

endpackage

`default_nettype wire

### hdl/tsq_cfg.sv
`default_nettype none

module tsq_cfg
  import tsq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output tsq_cfg_t         cfg_o
);

  tsq_cfg_t   cfg_q;
  logic       wr_en;
  logic [1:0] idx;

  assign idx   = paddr[3:2];
  assign wr_en = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_length      <= WINDOW_RST;
      cfg_q.baseline_count     <= COUNT_RST;
      cfg_q.settle_samples     <= SETTLE_RST;
      cfg_q.hold_timeout_ticks <= TIMEOUT_RST;
    end else if (wr_en) begin
      case (idx)
        REG_WINDOW:  cfg_q.window_length      <= pwdata[WLEN_BITS-1:0];
        REG_COUNT:   cfg_q.baseline_count     <= pwdata[COUNT_BITS-1:0];
        REG_SETTLE:  cfg_q.settle_samples     <= pwdata[COUNT_BITS-1:0];
        REG_TIMEOUT: cfg_q.hold_timeout_ticks <= pwdata[TICK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_WINDOW:  prdata = 32'(cfg_q.window_length);
      REG_COUNT:   prdata = 32'(cfg_q.baseline_count);
      REG_SETTLE:  prdata = 32'(cfg_q.settle_samples);
      REG_TIMEOUT: prdata = cfg_q.hold_timeout_ticks;
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hdl/tsq_datapath.sv
`default_nettype none

module tsq_datapath
  import tsq_pkg::*;
#(
  parameter int WINDOW_MAX = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire tsq_cfg_t cfg_i,
  input  wire tsq_in_t  in_data_i,
  input  wire tsq_cmd_t cmd_i,
  output tsq_sts_t      sts_o,
  output tsq_out_t      out_data_o
);

  // input request and per-item values
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [TICK_BITS-1:0]   now_q;
  logic [TICK_BITS-1:0]   dur_q;

  // qualifier state
  logic [WINDOW_MAX-1:0]  hist_q;
  logic                   touch_q;
  logic [TICK_BITS-1:0]   change_q;
  logic [SAMPLE_BITS-1:0] base_q;
  logic [COUNT_BITS-1:0]  rc_q;
  logic                   calib_q;
  logic [COUNT_BITS-1:0]  seen_q;
  logic [SUM_BITS-1:0]    sum_q;

  // multiplier and divider
  logic [SUM_BITS-1:0]    prod_q;
  logic [DVD_PAD-1:0]     quo_q;
  logic [COUNT_BITS-1:0]  rem_q;
  logic [COUNT_BITS-1:0]  dvs_q;
  logic [CNT_BITS-1:0]    cnt_q;

  tsq_out_t res_q;
  tsq_out_t out_q;

  logic [COUNT_BITS-1:0]  eff_cnt;
  logic [THR_BITS-1:0]    s_scaled;
  logic [THR_BITS-1:0]    b_scaled;
  logic                   trig;
  logic [WINDOW_MAX-1:0]  win_mask;
  logic [WINDOW_MAX-1:0]  hist_new;
  logic                   timed_out;
  logic                   next_touch;
  logic [COUNT_BITS-1:0]  rc_base;
  logic [COUNT_BITS-1:0]  rc_inc;
  logic [COUNT_BITS-1:0]  rc_new;
  logic                   settled;
  logic                   recal;
  logic                   track;
  logic [1:0]             edge_nx;
  logic [SUM_BITS-1:0]    sum_new;
  logic [COUNT_BITS-1:0]  seen_new;
  logic                   calib_done;
  logic [DVD_PAD-1:0]     quo_nx;
  logic [COUNT_BITS-1:0]  rem_nx;

  assign eff_cnt = (cfg_i.baseline_count == '0) ? COUNT_BITS'(1) : cfg_i.baseline_count;

  // window mask: zero length acts as one, oversize fills the history
  always_comb begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      win_mask[i] = (i == 0) || (WLEN_BITS'(i) < cfg_i.window_length);
    end
  end

  // trigger: sample > floor(base*201/200) is the same as 200*sample > 201*base
  assign s_scaled = THR_BITS'(sample_q) * THR_BITS'(THR_DEN);
  assign b_scaled = THR_BITS'(base_q) * THR_BITS'(THR_NUM);
  assign trig     = s_scaled > b_scaled;

  // debounce, timeout and release counting
  always_comb begin
    timed_out  = touch_q && (dur_q >= cfg_i.hold_timeout_ticks);
    hist_new   = timed_out ? '0 : WINDOW_MAX'({hist_q, trig});
    next_touch = touch_q ? ((hist_new & win_mask) != '0)
                         : ((hist_new & win_mask) == win_mask);
    rc_base    = timed_out ? cfg_i.settle_samples : rc_q;
    rc_inc     = (rc_base != RC_MAX) ? rc_base + COUNT_BITS'(1) : rc_base;
    rc_new     = next_touch ? '0 : rc_inc;
    settled    = !next_touch && (rc_inc >= cfg_i.settle_samples);
    recal      = settled && timed_out;
    track      = settled && !timed_out;
    if (next_touch && !touch_q) begin
      edge_nx = EDGE_RISE;
    end else if (!next_touch && touch_q) begin
      edge_nx = EDGE_FALL;
    end else begin
      edge_nx = EDGE_NONE;
    end
  end

  // calibration accumulate
  assign sum_new    = sum_q + SUM_BITS'(sample_q);
  assign seen_new   = (seen_q != RC_MAX) ? seen_q + COUNT_BITS'(1) : seen_q;
  assign calib_done = seen_new >= eff_cnt;

  // two restoring division steps
  always_comb begin
    logic [COUNT_BITS:0]  t;
    logic [DVD_PAD-1:0]   q;
    logic [COUNT_BITS-1:0] r;
    q = quo_q;
    r = rem_q;
    for (int k = 0; k < 2; k++) begin
      t = {r, q[DVD_PAD-1]};
      q = {q[DVD_PAD-2:0], 1'b0};
      if (t >= {1'b0, dvs_q}) begin
        t    = t - {1'b0, dvs_q};
        q[0] = 1'b1;
      end
      r = t[COUNT_BITS-1:0];
    end
    quo_nx = q;
    rem_nx = r;
  end

  // status to controller
  assign sts_o.calc_mul = !calib_q && track;
  assign sts_o.calc_div = calib_q ? calib_done : track;
  assign sts_o.div_last = (cnt_q == CNT_BITS'(1));

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q   <= '0;
      touch_q  <= 1'b0;
      change_q <= '0;
      base_q   <= '0;
      rc_q     <= '0;
      calib_q  <= 1'b1;
      seen_q   <= '0;
      sum_q    <= '0;
      cnt_q    <= '0;
    end else begin
      if (cmd_i.calc) begin
        if (calib_q) begin
          sum_q  <= sum_new;
          seen_q <= seen_new;
        end else begin
          hist_q  <= hist_new;
          touch_q <= next_touch;
          rc_q    <= rc_new;
          if (next_touch != touch_q) begin
            change_q <= now_q;
          end
          if (recal) begin
            calib_q <= 1'b1;
            seen_q  <= '0;
            sum_q   <= '0;
          end
        end
      end
      if (cmd_i.div_load) begin
        cnt_q <= CNT_BITS'(DIV_STEPS);
      end
      if (cmd_i.div_step) begin
        cnt_q <= cnt_q - CNT_BITS'(1);
      end
      // baseline update, end of calibration clears the qualifier
      if (cmd_i.wb) begin
        base_q <= quo_q[SAMPLE_BITS-1:0];
        if (calib_q) begin
          calib_q <= 1'b0;
          seen_q  <= '0;
          sum_q   <= '0;
          touch_q <= 1'b0;
          hist_q  <= '0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= in_data_i.sample;
      now_q    <= in_data_i.now_ticks;
      dur_q    <= in_data_i.now_ticks - change_q;
    end
    if (cmd_i.calc) begin
      res_q.state_duration <= dur_q;
      if (calib_q) begin
        res_q.edge_res    <= EDGE_NONE;
        res_q.pressed     <= 1'b0;
        res_q.calibrating <= 1'b1;
      end else begin
        res_q.edge_res    <= edge_nx;
        res_q.pressed     <= next_touch;
        res_q.calibrating <= 1'b0;
      end
    end
    if (cmd_i.mul) begin
      prod_q <= SUM_BITS'(base_q) * SUM_BITS'(eff_cnt - COUNT_BITS'(1));
    end
    if (cmd_i.div_load) begin
      quo_q <= calib_q ? DVD_PAD'(sum_q)
                       : DVD_PAD'({1'b0, prod_q} + DVD_BITS'(sample_q));
      rem_q <= '0;
      dvs_q <= eff_cnt;
    end
    if (cmd_i.div_step) begin
      quo_q <= quo_nx;
      rem_q <= rem_nx;
    end
    if (cmd_i.push) begin
      out_q <= res_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

### hdl/tsq_ctrl.sv
`default_nettype none

module tsq_ctrl
  import tsq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  input  wire tsq_sts_t sts_i,
  output tsq_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CALC = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_WB   = 3'd5;
  localparam logic [2:0] S_PUSH = 3'd6;

  logic [2:0] state_q;
  logic [2:0] state_d;
  logic       out_valid_q;
  logic       out_valid_d;
  logic       out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // sequencing
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        if (sts_i.calc_mul) begin
          state_d = S_MUL;
        end else if (sts_i.calc_div) begin
          state_d = S_LOAD;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        cmd_o.wb = 1'b1;
        state_d  = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // accepted request always goes to the decision step
  a_accept_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_CALC))
    else $error("accepted request did not enter decision step");

  // a pushed result is presented next cycle
  a_push_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |=> out_valid_o)
    else $error("pushed result not valid");

  // push never overwrites a waiting result
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");

  // the last divider step always hands over to write back
  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && sts_i.div_last) |=> (state_q == S_WB))
    else $error("divider did not hand over to write back");

endmodule

`default_nettype wire

### hdl/touch_sense_qualifier.sv
// a request passes the load, decision and push states; a baseline recompute (calibration
//   end or tracking) adds multiply (tracking only), divider load, divide and write-back
// a new request is taken only back in idle, after the previous result is pushed; the
//   two-bit-per-cycle divider (21 steps) recomputes the baseline
// reset: asynchronous, clears the qualifier and starts a fresh calibration
`default_nettype none

module touch_sense_qualifier
  import tsq_pkg::*;
#(
  parameter int WINDOW_MAX = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire tsq_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output tsq_out_t         out_data_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  tsq_cfg_t cfg;
  tsq_cmd_t cmd;
  tsq_sts_t sts;

  assign pready = 1'b1;

  // configuration registers
  tsq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // sequencer
  tsq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // qualifier datapath
  tsq_datapath #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire
